// ===== hdl/prefix_code_bit_packer_defines.svh =====
// Assertion helpers used by the packer RTL.
`ifndef PREFIX_CODE_BIT_PACKER_DEFINES_SVH
`define PREFIX_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcbp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcbp: next-cycle check failed");

`endif

// ===== hdl/pcbp_pkg.sv =====
`timescale 1ns / 1ps
package pcbp_pkg;

  // Running bit total width (saturating) and the width of the reported field
  localparam int TOTAL_WIDTH = 16;
  localparam int TOTAL_OUT_W = 16;

  // Code geometry: 2-bit group followed by up to 4 index bits
  localparam int CODE_W = 6;
  localparam int LEN_W  = 3;

  // Queue between classifier and packer
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Character range bounds
  localparam logic [7:0] CHR_A = 8'd97;   // a
  localparam logic [7:0] CHR_B = 8'd98;   // b
  localparam logic [7:0] CHR_C = 8'd99;   // c
  localparam logic [7:0] CHR_F = 8'd102;  // f
  localparam logic [7:0] CHR_G = 8'd103;  // g
  localparam logic [7:0] CHR_N = 8'd110;  // n
  localparam logic [7:0] CHR_O = 8'd111;  // o

  // Group numbers
  localparam logic [1:0] GRP_AB    = 2'd0;
  localparam logic [1:0] GRP_CF    = 2'd1;
  localparam logic [1:0] GRP_GN    = 2'd2;
  localparam logic [1:0] GRP_OTHER = 2'd3;

  // Classified letter waiting to be packed
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              fin;
  } pcbp_entry_t;

  // One outgoing byte transaction
  typedef struct packed {
    logic [7:0]             byte_bits;
    logic [3:0]             count;
    logic                   msg_end;
    logic [TOTAL_OUT_W-1:0] total;
  } pcbp_result_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic not_empty;
  } pcbp_qstat_t;

endpackage

// ===== hdl/prefix_code_bit_packer.sv =====
`timescale 1ns / 1ps
// A taken letter enters the queue; the packer then pops it and registers any byte it completes.
// One letter per cycle while the queue has room; a two-byte flush holds the packer for both bytes.
// A 4-entry queue between classifier and packer absorbs output stalls.
// Reset (rst, synchronous): queue emptied, pending bits, bit count and running total cleared.
module prefix_code_bit_packer
  import pcbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [7:0]             letter,
  input  logic                   final_letter,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             packed_byte,
  output logic [3:0]             valid_count,
  output logic                   message_end,
  output logic [TOTAL_OUT_W-1:0] total_bits
);

  pcbp_qstat_t  qstat;
  pcbp_entry_t  push_entry;
  pcbp_entry_t  pop_entry;
  pcbp_result_t result;
  logic         push;
  logic         pop;

  pcbp_front u_front (
    .letter       (letter),
    .final_letter (final_letter),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .qstat        (qstat),
    .push         (push),
    .push_entry   (push_entry)
  );

  pcbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  pcbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .entry        (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign packed_byte = result.byte_bits;
  assign valid_count = result.count;
  assign message_end = result.msg_end;
  assign total_bits  = result.total;

endmodule

// ===== hdl/pcbp_front.sv =====
`timescale 1ns / 1ps
module pcbp_front
  import pcbp_pkg::*;
(
  input  logic        [7:0] letter,
  input  logic              final_letter,
  input  logic              item_valid,
  output logic              item_stall,
  input  pcbp_qstat_t       qstat,
  output logic              push,
  output pcbp_entry_t       push_entry
);

  logic [1:0] group;
  logic [3:0] index;
  logic [7:0] offs;

  // Map the character to group and index
  always_comb begin
    offs  = letter - CHR_O;
    group = GRP_OTHER;
    index = offs[3:0];
    case (letter) inside
      [CHR_A:CHR_B]: begin
        group = GRP_AB;
        index = 4'(letter - CHR_A);
      end
      [CHR_C:CHR_F]: begin
        group = GRP_CF;
        index = 4'(letter - CHR_C);
      end
      [CHR_G:CHR_N]: begin
        group = GRP_GN;
        index = 4'(letter - CHR_G);
      end
      default: begin
        group = GRP_OTHER;
        index = offs[3:0];
      end
    endcase
  end

  // Code is group bits then index bits, LSB first; length is group + 3
  always_comb begin
    push_entry.code = {index, group};
    push_entry.len  = LEN_W'({1'b0, group} + 3'd3);
    push_entry.fin  = final_letter;
  end

  assign item_stall = qstat.full;
  assign push       = item_valid && !qstat.full;

endmodule

// ===== hdl/pcbp_fifo.sv =====
`timescale 1ns / 1ps
module pcbp_fifo
  import pcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pcbp_entry_t push_entry,
  input  logic        pop,
  output pcbp_entry_t pop_entry,
  output pcbp_qstat_t qstat
);

  pcbp_entry_t          slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   fill;

  function automatic logic [FIFO_AW-1:0] bump(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.full      = (fill == FIFO_CW'(FIFO_DEPTH));
  assign qstat.not_empty = (fill != '0);
  assign pop_entry       = slots[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

// ===== hdl/pcbp_back.sv =====
`timescale 1ns / 1ps
`include "prefix_code_bit_packer_defines.svh"
module pcbp_back
  import pcbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  pcbp_qstat_t  qstat,
  input  pcbp_entry_t  entry,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_stall,
  output pcbp_result_t result
);

  // Packing state
  logic [6:0]             pending_bits;
  logic [2:0]             pending_count;
  logic [TOTAL_WIDTH-1:0] bit_total;

  // Second byte of a flush that produced two transactions
  logic                   hold_valid;
  pcbp_result_t           hold;

  logic [12:0]            acc;
  logic [12:0]            acc2;
  logic [3:0]             n;
  logic [3:0]             n2;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] total_next;
  logic                   has_byte;
  logic                   has_tail;
  logic                   out_free;
  pcbp_result_t           r_byte;
  pcbp_result_t           r_tail;

  // Append the code to the pending bits and form the full byte and the final flush
  always_comb begin
    acc      = {6'd0, pending_bits} | (13'(entry.code) << pending_count);
    n        = {1'b0, pending_count} + {1'b0, entry.len};
    sum      = {1'b0, bit_total} + (TOTAL_WIDTH + 1)'(entry.len);
    total_next = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
    has_byte = (n >= 4'd8);
    acc2     = has_byte ? (acc >> 8) : acc;
    n2       = has_byte ? (n - 4'd8) : n;
    has_tail = entry.fin && (n2 != 4'd0);

    r_byte.byte_bits = acc[7:0];
    r_byte.count     = 4'd8;
    r_byte.msg_end   = entry.fin && (n2 == 4'd0);
    r_byte.total     = TOTAL_OUT_W'(total_next);

    r_tail.byte_bits = acc2[7:0];
    r_tail.count     = n2;
    r_tail.msg_end   = 1'b1;
    r_tail.total     = TOTAL_OUT_W'(total_next);
  end

  assign out_free = !result_valid || !result_stall;
  assign pop      = qstat.not_empty && out_free && !hold_valid;

  // Control: state and output valids
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      bit_total     <= '0;
      result_valid  <= 1'b0;
      hold_valid    <= 1'b0;
    end else begin
      if (hold_valid) begin
        if (out_free) begin
          result_valid <= 1'b1;
          hold_valid   <= 1'b0;
        end
      end else if (pop) begin
        result_valid <= has_byte || has_tail;
        hold_valid   <= has_byte && has_tail;
        if (entry.fin) begin
          pending_bits  <= '0;
          pending_count <= '0;
          bit_total     <= '0;
        end else begin
          pending_bits  <= acc2[6:0];
          pending_count <= n2[2:0];
          bit_total     <= total_next;
        end
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (hold_valid) begin
      if (out_free) result <= hold;
    end else if (pop) begin
      result <= has_byte ? r_byte : r_tail;
      hold   <= r_tail;
    end
  end

  // A held second byte always sits behind a visible first one
  `PCBP_ASSERT_NOW(a_hold_behind_out, clk, rst, hold_valid, result_valid)
  // Byte bit counts stay within one byte
  `PCBP_ASSERT_NOW(a_count_range, clk, rst, result_valid,
                   (result.count != 4'd0) && (result.count <= 4'd8))
  // A final letter leaves the packer empty for the next message
  `PCBP_ASSERT_NEXT(a_fin_clears, clk, rst, pop && entry.fin,
                    (pending_count == 3'd0) && (bit_total == '0))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import pcbp_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int TOTAL_MAX   = (1 << TOTAL_WIDTH) - 1;

  logic       clk;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [7:0] letter = 8'd0;
  logic       final_letter = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] packed_byte;
  logic [3:0] valid_count;
  logic       message_end;
  logic [TOTAL_OUT_W-1:0] total_bits;

  prefix_code_bit_packer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .letter       (letter),
    .final_letter (final_letter),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .packed_byte  (packed_byte),
    .valid_count  (valid_count),
    .message_end  (message_end),
    .total_bits   (total_bits)
  );

  // Packer state mirrored by the predictor
  logic [6:0]   pend_bits = 7'd0;
  int           pend_cnt = 0;
  int           msg_total = 0;
  pcbp_result_t exp_bytes[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  sender_gaps = 1'b0;
  bit  stall_on = 1'b0;
  int  stall_hold = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Mostly a..z, some arbitrary character codes
  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(0, 255));
  endfunction

  // Encode one letter into the pending bit stream and queue the bytes it completes
  function automatic void predict_bytes(input logic [7:0] ch, input logic fin);
    logic [1:0]   grp;
    logic [3:0]   idx;
    logic [5:0]   code;
    logic [15:0]  acc;
    int           len;
    int           n;
    pcbp_result_t r;
    if (ch >= CHR_A && ch <= CHR_B) begin
      grp = GRP_AB;
      idx = 4'(ch - CHR_A);
    end else if (ch >= CHR_C && ch <= CHR_F) begin
      grp = GRP_CF;
      idx = 4'(ch - CHR_C);
    end else if (ch >= CHR_G && ch <= CHR_N) begin
      grp = GRP_GN;
      idx = 4'(ch - CHR_G);
    end else begin
      grp = GRP_OTHER;
      idx = 4'(ch - CHR_O);
    end
    len  = int'(grp) + 3;
    code = {idx, grp};
    acc  = 16'(pend_bits) | (16'(code) << pend_cnt);
    n    = pend_cnt + len;

    msg_total = msg_total + len;
    if (msg_total > TOTAL_MAX) msg_total = TOTAL_MAX;

    // Full byte
    if (n >= 8) begin
      r.byte_bits = acc[7:0];
      r.count     = 4'd8;
      r.msg_end   = fin && (n == 8);
      r.total     = TOTAL_OUT_W'(msg_total);
      exp_bytes.push_back(r);
      acc = acc >> 8;
      n   = n - 8;
    end
    // Zero-filled flush on the last letter
    if (fin && n > 0) begin
      r.byte_bits = 8'(acc & ((16'd1 << n) - 16'd1));
      r.count     = 4'(n);
      r.msg_end   = 1'b1;
      r.total     = TOTAL_OUT_W'(msg_total);
      exp_bytes.push_back(r);
      n = 0;
    end

    if (fin) begin
      pend_bits = 7'd0;
      pend_cnt  = 0;
      msg_total = 0;
    end else begin
      pend_cnt  = n;
      pend_bits = 7'(acc & ((16'd1 << n) - 16'd1));
    end
  endfunction

  // Send one letter; predict once the transaction is taken
  task automatic send_letter(input logic [7:0] ch, input logic fin);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    letter       <= ch;
    final_letter <= fin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_bytes(ch, fin);
    items_sent++;
  endtask

  // Hold off the sender until every predicted byte has come out
  task automatic wait_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (exp_bytes.size() != 0) @(posedge clk);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold   <= stall_hold - 1;
      result_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_hold   <= pick_gap();
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each output transaction against the oldest prediction
  always @(posedge clk) begin
    pcbp_result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (exp_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte: byte=%h count=%0d end=%b total=%0d",
                   packed_byte, valid_count, message_end, total_bits);
      end else begin
        want = exp_bytes.pop_front();
        if (packed_byte !== want.byte_bits || valid_count !== want.count ||
            message_end !== want.msg_end || total_bits !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: exp %h/%0d/%b/%0d got %h/%0d/%b/%0d",
                     want.byte_bits, want.count, want.msg_end, want.total,
                     packed_byte, valid_count, message_end, total_bits);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One code from each group, both ends of each range
  task automatic test_code_groups();
    logic [7:0] seq[8];
    seq = '{8'd97, 8'd98, 8'd99, 8'd102, 8'd103, 8'd110, 8'd111, 8'd122};
    foreach (seq[i]) send_letter(seq[i], i == 7);
  endtask

  // Codes outside a..z, including both extremes of the field
  task automatic test_other_codes();
    send_letter(8'd0, 1'b0);
    send_letter(8'd255, 1'b0);
    send_letter(8'd96, 1'b0);
    send_letter(8'd123, 1'b0);
    send_letter(8'd128, 1'b0);
    send_letter(8'h7f, 1'b1);
  endtask

  // Exact byte fill on the last letter, single short flush, byte plus flush
  task automatic test_byte_boundary();
    send_letter(8'd97, 1'b0);
    send_letter(8'd103, 1'b1);
    send_letter(8'd98, 1'b1);
    send_letter(8'd122, 1'b0);
    send_letter(8'd122, 1'b1);
    repeat (3) send_letter(8'd99, 1'b0);
    send_letter(8'd99, 1'b1);
  endtask

  // Sender stops mid-message until the output side is empty
  task automatic test_drain_pause();
    repeat (12) send_letter(pick_letter(), 1'b0);
    wait_drain();
    repeat (11) send_letter(pick_letter(), 1'b0);
    send_letter(pick_letter(), 1'b1);
  endtask

  // Random messages of mostly short length
  task automatic test_random_messages();
    int len;
    while (items_sent < 1700) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      stall_on    = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) send_letter(pick_letter(), i == len - 1);
    end
  endtask

  // One long message of six-bit codes keeps the running total climbing
  task automatic test_long_message();
    sender_gaps = 1'b0;
    stall_on    = 1'b1;
    for (int i = 0; i < 300; i++) send_letter(8'($urandom_range(111, 122)), i == 299);
    send_letter(8'd97, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_gaps = 1'b1;
    stall_on    = 1'b1;
    test_code_groups();
    test_other_codes();
    test_byte_boundary();
    test_drain_pause();
    test_random_messages();
    test_long_message();

    wait_drain();
    repeat (20) @(posedge clk);
    if (exp_bytes.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pcbp_pkg.sv
hdl/pcbp_front.sv
hdl/pcbp_fifo.sv
hdl/pcbp_back.sv
hdl/prefix_code_bit_packer.sv
tb/tb.sv
